/* rtl/triangle_face_normal_top_defines.svh */
// Assertion macros used by the checker file of triangle_face_normal_top.
// Depends on nothing; included by bare file name.
`ifndef TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH
`define TRIANGLE_FACE_NORMAL_TOP_DEFINES_SVH

// Checked property, ignored while reset is held.
`define TFN_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("triangle normal check failed");

// Checked property, also evaluated during reset.
`define TFN_ASSERT_RST(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("triangle normal reset check failed");

`endif

/* rtl/tfn_pkg.sv */
// Types and width constants for the triangle face normal pipeline.
// No dependencies; used by triangle_face_normal_top and tfn_checker.
package tfn_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int EDGE_W      = COORD_WIDTH + 1;
    localparam int PROD_W      = 2 * EDGE_W;
    localparam int CROSS_W     = PROD_W + 1;
    localparam int SH_W        = $clog2(CROSS_W);
    localparam int NORM_W      = 30;
    localparam int NORM_MSB    = NORM_W - 1;
    localparam int SQ_W        = 2 * NORM_W;
    localparam int SUM_W       = SQ_W + 2;
    localparam int TRIAL_W     = SUM_W + 2;
    localparam int ROOT_W      = SUM_W / 2;
    localparam int FRAC_W      = 14;
    localparam int Q_W         = FRAC_W + 1;
    localparam int NUM_W       = NORM_W + FRAC_W + 1;
    localparam int OUT_W       = 16;
    localparam int UNIT_ONE    = 1 << FRAC_W;

    // edges, products, cross, magnitude, shift amount, shift, squares, sum
    localparam int FRONT_STG   = 8;
    localparam int NSTG        = FRONT_STG + ROOT_W + 1 + Q_W + 1;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] ax;
        logic signed [COORD_WIDTH-1:0] ay;
        logic signed [COORD_WIDTH-1:0] az;
        logic signed [COORD_WIDTH-1:0] bx;
        logic signed [COORD_WIDTH-1:0] by_coord;
        logic signed [COORD_WIDTH-1:0] bz;
        logic signed [COORD_WIDTH-1:0] cx;
        logic signed [COORD_WIDTH-1:0] cy;
        logic signed [COORD_WIDTH-1:0] cz;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_W-1:0] nx;
        logic signed [OUT_W-1:0] ny;
        logic signed [OUT_W-1:0] nz;
        logic                    degenerate;
    } t_out_item;

endpackage

/* rtl/triangle_face_normal_top.sv */
// Channel   | Dir | Handshake          | Payload
// input     | in  | i_valid / o_ready  | i_item (tfn_pkg::t_in_item)
// result    | out | o_valid / i_ready  | o_item (tfn_pkg::t_out_item)
// One triangle enters per cycle while the pipe is not held; the pipe has tfn_pkg::NSTG stages.
// Depth is set by the square root (one root bit a stage) and the three
// parallel dividers (one quotient bit a stage). The last stage is the output
// register; the whole pipe, bubbles included, holds while the output register
// has an item that is not taken.
// Synchronous reset clears only the valid bits.
// Depends on tfn_pkg.
module triangle_face_normal_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  tfn_pkg::t_in_item   i_item,
    output logic                o_valid,
    input  logic                i_ready,
    output tfn_pkg::t_out_item  o_item
);

    localparam int RS = tfn_pkg::ROOT_W;
    localparam int QS = tfn_pkg::Q_W;

    logic                           w_en;
    logic [tfn_pkg::NSTG-1:0]       r_vld;

    logic signed [tfn_pkg::EDGE_W-1:0]  r_u [3];
    logic signed [tfn_pkg::EDGE_W-1:0]  r_v [3];
    logic signed [tfn_pkg::PROD_W-1:0]  r_p [6];
    logic signed [tfn_pkg::CROSS_W-1:0] r_w [3];
    logic [tfn_pkg::CROSS_W-1:0]        r_mag4 [3];
    logic [2:0]                         r_neg4;
    logic [tfn_pkg::CROSS_W-1:0]        r_mag5 [3];
    logic [2:0]                         r_neg5;
    logic                               r_dg5;
    logic                               r_shl5;
    logic [tfn_pkg::SH_W-1:0]           r_sam5;
    logic [tfn_pkg::NORM_W-1:0]         r_mn6 [3];
    logic [2:0]                         r_neg6;
    logic                               r_dg6;
    logic [tfn_pkg::NORM_W-1:0]         r_mn7 [3];
    logic [tfn_pkg::SQ_W-1:0]           r_sq7 [3];
    logic [2:0]                         r_neg7;
    logic                               r_dg7;
    logic [tfn_pkg::NORM_W-1:0]         r_mn8 [3];
    logic [tfn_pkg::SUM_W-1:0]          r_sum8;
    logic [2:0]                         r_neg8;
    logic                               r_dg8;

    logic [tfn_pkg::CROSS_W-1:0]        w_or;
    logic [tfn_pkg::SH_W-1:0]           w_msb;

    // square root stages
    logic [tfn_pkg::SUM_W-1:0]   r_sr_rem  [RS];
    logic [tfn_pkg::ROOT_W-1:0]  r_sr_root [RS];
    logic [tfn_pkg::NORM_W-1:0]  r_sr_mn   [RS][3];
    logic [2:0]                  r_sr_neg  [RS];
    logic                        r_sr_dg   [RS];

    // numerator stage
    logic [tfn_pkg::NUM_W-1:0]   r_nm_num [3];
    logic [tfn_pkg::ROOT_W-1:0]  r_nm_len;
    logic [2:0]                  r_nm_neg;
    logic                        r_nm_dg;

    // divider stages
    logic [tfn_pkg::NUM_W-1:0]   r_dv_rem [QS][3];
    logic [tfn_pkg::Q_W-1:0]     r_dv_q   [QS][3];
    logic [tfn_pkg::ROOT_W-1:0]  r_dv_len [QS];
    logic [2:0]                  r_dv_neg [QS];
    logic                        r_dv_dg  [QS];

    logic [tfn_pkg::OUT_W-1:0]   r_n [3];
    logic                        r_dg;

    assign w_en    = !r_vld[tfn_pkg::NSTG-1] || i_ready;
    assign o_ready = w_en;
    assign o_valid = r_vld[tfn_pkg::NSTG-1];
    assign o_item.nx         = r_n[0];
    assign o_item.ny         = r_n[1];
    assign o_item.nz         = r_n[2];
    assign o_item.degenerate = r_dg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[tfn_pkg::NSTG-2:0], i_valid};
        end
    end

    // edges, products, cross product, magnitudes
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_u[0] <= tfn_pkg::EDGE_W'(i_item.bx) - tfn_pkg::EDGE_W'(i_item.ax);
            r_u[1] <= tfn_pkg::EDGE_W'(i_item.by_coord) - tfn_pkg::EDGE_W'(i_item.ay);
            r_u[2] <= tfn_pkg::EDGE_W'(i_item.bz) - tfn_pkg::EDGE_W'(i_item.az);
            r_v[0] <= tfn_pkg::EDGE_W'(i_item.cx) - tfn_pkg::EDGE_W'(i_item.ax);
            r_v[1] <= tfn_pkg::EDGE_W'(i_item.cy) - tfn_pkg::EDGE_W'(i_item.ay);
            r_v[2] <= tfn_pkg::EDGE_W'(i_item.cz) - tfn_pkg::EDGE_W'(i_item.az);

            r_p[0] <= r_u[1] * r_v[2];
            r_p[1] <= r_u[2] * r_v[1];
            r_p[2] <= r_u[2] * r_v[0];
            r_p[3] <= r_u[0] * r_v[2];
            r_p[4] <= r_u[0] * r_v[1];
            r_p[5] <= r_u[1] * r_v[0];

            for (int k = 0; k < 3; k++) begin
                r_w[k] <= tfn_pkg::CROSS_W'(r_p[2*k]) - tfn_pkg::CROSS_W'(r_p[2*k+1]);
                r_neg4[k] <= r_w[k][tfn_pkg::CROSS_W-1];
                r_mag4[k] <= r_w[k][tfn_pkg::CROSS_W-1] ? tfn_pkg::CROSS_W'(-r_w[k])
                                                         : tfn_pkg::CROSS_W'(r_w[k]);
            end
        end
    end

    // leading one of the largest magnitude is the leading one of their OR
    always_comb begin
        w_or  = r_mag4[0] | r_mag4[1] | r_mag4[2];
        w_msb = '0;
        for (int b = 0; b < tfn_pkg::CROSS_W; b++) begin
            if (w_or[b]) begin
                w_msb = tfn_pkg::SH_W'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_mag5 <= r_mag4;
            r_neg5 <= r_neg4;
            r_dg5  <= (w_or == '0);
            if (w_msb >= tfn_pkg::SH_W'(tfn_pkg::NORM_MSB)) begin
                r_shl5 <= 1'b0;
                r_sam5 <= w_msb - tfn_pkg::SH_W'(tfn_pkg::NORM_MSB);
            end else begin
                r_shl5 <= 1'b1;
                r_sam5 <= tfn_pkg::SH_W'(tfn_pkg::NORM_MSB) - w_msb;
            end

            for (int k = 0; k < 3; k++) begin
                r_mn6[k] <= r_shl5 ? tfn_pkg::NORM_W'(r_mag5[k] << r_sam5)
                                   : tfn_pkg::NORM_W'(r_mag5[k] >> r_sam5);
            end
            r_neg6 <= r_neg5;
            r_dg6  <= r_dg5;

            for (int k = 0; k < 3; k++) begin
                r_sq7[k] <= tfn_pkg::SQ_W'(r_mn6[k]) * tfn_pkg::SQ_W'(r_mn6[k]);
            end
            r_mn7  <= r_mn6;
            r_neg7 <= r_neg6;
            r_dg7  <= r_dg6;

            r_sum8 <= tfn_pkg::SUM_W'(r_sq7[0]) + tfn_pkg::SUM_W'(r_sq7[1])
                    + tfn_pkg::SUM_W'(r_sq7[2]);
            r_mn8  <= r_mn7;
            r_neg8 <= r_neg7;
            r_dg8  <= r_dg7;
        end
    end

    // integer square root, one root bit per stage, most significant first
    for (genvar j = 0; j < RS; j++) begin : g_sqrt
        localparam int BK = RS - 1 - j;
        logic [tfn_pkg::SUM_W-1:0]   w_rem_in;
        logic [tfn_pkg::ROOT_W-1:0]  w_root_in;
        logic [tfn_pkg::TRIAL_W-1:0] w_trial;

        if (j == 0) begin : g_first
            assign w_rem_in  = r_sum8;
            assign w_root_in = '0;
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sr_mn[j]  <= r_mn8;
                    r_sr_neg[j] <= r_neg8;
                    r_sr_dg[j]  <= r_dg8;
                end
            end
        end else begin : g_next
            assign w_rem_in  = r_sr_rem[j-1];
            assign w_root_in = r_sr_root[j-1];
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sr_mn[j]  <= r_sr_mn[j-1];
                    r_sr_neg[j] <= r_sr_neg[j-1];
                    r_sr_dg[j]  <= r_sr_dg[j-1];
                end
            end
        end

        assign w_trial = (tfn_pkg::TRIAL_W'(w_root_in) << (BK + 1))
                       + (tfn_pkg::TRIAL_W'(1) << (2 * BK));

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (tfn_pkg::TRIAL_W'(w_rem_in) >= w_trial) begin
                    r_sr_rem[j]  <= tfn_pkg::SUM_W'(tfn_pkg::TRIAL_W'(w_rem_in) - w_trial);
                    r_sr_root[j] <= w_root_in | (tfn_pkg::ROOT_W'(1) << BK);
                end else begin
                    r_sr_rem[j]  <= w_rem_in;
                    r_sr_root[j] <= w_root_in;
                end
            end
        end
    end

    // numerators with half the length added for rounding
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                r_nm_num[k] <= (tfn_pkg::NUM_W'(r_sr_mn[RS-1][k]) << tfn_pkg::FRAC_W)
                             + tfn_pkg::NUM_W'(r_sr_root[RS-1] >> 1);
            end
            r_nm_len <= r_sr_root[RS-1];
            r_nm_neg <= r_sr_neg[RS-1];
            r_nm_dg  <= r_sr_dg[RS-1];
        end
    end

    // three restoring dividers, one quotient bit per stage
    for (genvar j = 0; j < QS; j++) begin : g_div
        localparam int BK = QS - 1 - j;
        logic [tfn_pkg::NUM_W-1:0]   w_rem_in [3];
        logic [tfn_pkg::Q_W-1:0]     w_q_in   [3];
        logic [tfn_pkg::ROOT_W-1:0]  w_len_in;
        logic [2:0]                  w_neg_in;
        logic                        w_dg_in;
        logic [tfn_pkg::NUM_W-1:0]   w_den;

        if (j == 0) begin : g_first
            assign w_rem_in = r_nm_num;
            assign w_q_in   = '{default: '0};
            assign w_len_in = r_nm_len;
            assign w_neg_in = r_nm_neg;
            assign w_dg_in  = r_nm_dg;
        end else begin : g_next
            assign w_rem_in = r_dv_rem[j-1];
            assign w_q_in   = r_dv_q[j-1];
            assign w_len_in = r_dv_len[j-1];
            assign w_neg_in = r_dv_neg[j-1];
            assign w_dg_in  = r_dv_dg[j-1];
        end

        assign w_den = tfn_pkg::NUM_W'(w_len_in) << BK;

        always_ff @(posedge i_clk) begin
            if (w_en) begin
                for (int k = 0; k < 3; k++) begin
                    if (w_rem_in[k] >= w_den) begin
                        r_dv_rem[j][k] <= w_rem_in[k] - w_den;
                        r_dv_q[j][k]   <= w_q_in[k] | (tfn_pkg::Q_W'(1) << BK);
                    end else begin
                        r_dv_rem[j][k] <= w_rem_in[k];
                        r_dv_q[j][k]   <= w_q_in[k];
                    end
                end
                r_dv_len[j] <= w_len_in;
                r_dv_neg[j] <= w_neg_in;
                r_dv_dg[j]  <= w_dg_in;
            end
        end
    end

    // apply signs; a zero cross product gives a zero normal
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 3; k++) begin
                if (r_dv_dg[QS-1]) begin
                    r_n[k] <= '0;
                end else if (r_dv_neg[QS-1][k]) begin
                    r_n[k] <= '0 - tfn_pkg::OUT_W'(r_dv_q[QS-1][k]);
                end else begin
                    r_n[k] <= tfn_pkg::OUT_W'(r_dv_q[QS-1][k]);
                end
            end
            r_dg <= r_dv_dg[QS-1];
        end
    end

endmodule

/* rtl/tfn_checker.sv */
// Port-level checks for triangle_face_normal_top, attached by bind.
// Depends on tfn_pkg and triangle_face_normal_top_defines.svh.
`include "triangle_face_normal_top_defines.svh"

module tfn_checker (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                o_ready,
    input  logic                o_valid,
    input  logic                i_ready,
    input  tfn_pkg::t_out_item  o_item
);

    localparam logic signed [tfn_pkg::OUT_W-1:0] ONE_P = tfn_pkg::OUT_W'(tfn_pkg::UNIT_ONE);
    localparam logic signed [tfn_pkg::OUT_W-1:0] ONE_N = -ONE_P;

    logic w_nx_ok;
    logic w_ny_ok;
    logic w_nz_ok;
    logic w_zero;

    assign w_nx_ok = (o_item.nx <= ONE_P) && (o_item.nx >= ONE_N);
    assign w_ny_ok = (o_item.ny <= ONE_P) && (o_item.ny >= ONE_N);
    assign w_nz_ok = (o_item.nz <= ONE_P) && (o_item.nz >= ONE_N);
    assign w_zero  = (o_item.nx == '0) && (o_item.ny == '0) && (o_item.nz == '0);

    `TFN_ASSERT_RST(a_reset_empty, i_clk, !i_rst_n |=> !o_valid)

    `TFN_ASSERT(a_degen_zero, i_clk, i_rst_n, (o_valid && o_item.degenerate) |-> w_zero)

    `TFN_ASSERT(a_unit_range, i_clk, i_rst_n, o_valid |-> (w_nx_ok && w_ny_ok && w_nz_ok))

    `TFN_ASSERT(a_ready_when_empty, i_clk, i_rst_n, (!o_valid || i_ready) |-> o_ready)

    `TFN_ASSERT(a_out_hold, i_clk, i_rst_n, (o_valid && !i_ready) |=> (o_valid && $stable(o_item)))

endmodule

bind triangle_face_normal_top tfn_checker u_tfn_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_item  (o_item)
);

/* sim/triangle_face_normal_top_test.sv */
// Testbench for triangle_face_normal_top: random and corner triangles, face normals
// predicted in Q1.14 and compared field by field. Depends on tfn_pkg and the block.
`timescale 1ns / 100ps

module triangle_face_normal_top_test;

    localparam int LATENCY = tfn_pkg::NSTG;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int N_RANDOM = 400;

    // Predicted normals, oldest first
    class normal_scoreboard;
        tfn_pkg::t_out_item pending_normals[$];
        int        n_errors;
        int        n_checked;

        function logic [63:0] isqrt(logic [63:0] s);
            logic [63:0] root;
            logic [63:0] bitv;
            root = 0;
            bitv = 64'd1 << 62;
            while (bitv > s) bitv = bitv >> 2;
            while (bitv != 0) begin
                if (s >= root + bitv) begin
                    s = s - (root + bitv);
                    root = (root >> 1) + bitv;
                end else begin
                    root = root >> 1;
                end
                bitv = bitv >> 2;
            end
            return root;
        endfunction

        function tfn_pkg::t_out_item face_normal(tfn_pkg::t_in_item t);
            longint du[3], dv[3], w[3];
            logic [63:0] m[3], big, sum, len, q, v;
            tfn_pkg::t_out_item r;
            du[0] = longint'(t.bx) - longint'(t.ax);
            du[1] = longint'(t.by_coord) - longint'(t.ay);
            du[2] = longint'(t.bz) - longint'(t.az);
            dv[0] = longint'(t.cx) - longint'(t.ax);
            dv[1] = longint'(t.cy) - longint'(t.ay);
            dv[2] = longint'(t.cz) - longint'(t.az);
            w[0] = du[1] * dv[2] - du[2] * dv[1];
            w[1] = du[2] * dv[0] - du[0] * dv[2];
            w[2] = du[0] * dv[1] - du[1] * dv[0];
            big = 0;
            for (int k = 0; k < 3; k++) begin
                m[k] = (w[k] < 0) ? -w[k] : w[k];
                if (m[k] > big) big = m[k];
            end
            r = '0;
            if (big == 0) begin
                r.degenerate = 1'b1;
                return r;
            end
            while (big >= (64'd1 << 30)) begin
                big = big >> 1;
                for (int k = 0; k < 3; k++) m[k] = m[k] >> 1;
            end
            while (big < (64'd1 << 29)) begin
                big = big << 1;
                for (int k = 0; k < 3; k++) m[k] = m[k] << 1;
            end
            sum = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
            len = isqrt(sum);
            for (int k = 0; k < 3; k++) begin
                q = ((m[k] << 14) + (len >> 1)) / len;
                v = (w[k] < 0) ? -q : q;
                if (k == 0) r.nx = v[15:0];
                else if (k == 1) r.ny = v[15:0];
                else r.nz = v[15:0];
            end
            return r;
        endfunction

        function void note_triangle(tfn_pkg::t_in_item t);
            pending_normals = {pending_normals, face_normal(t)};
        endfunction

        task report(string what, int got, int want);
            $display("MISMATCH %s: got %0d expected %0d (result %0d)",
                     what, got, want, n_checked);
            n_errors++;
        endtask

        task check_normal(tfn_pkg::t_out_item got);
            tfn_pkg::t_out_item want;
            if (pending_normals.size() == 0) begin
                report("unexpected result", 1, 0);
                return;
            end
            want = pending_normals.pop_front();
            if (got.nx !== want.nx) report("nx", got.nx, want.nx);
            if (got.ny !== want.ny) report("ny", got.ny, want.ny);
            if (got.nz !== want.nz) report("nz", got.nz, want.nz);
            if (got.degenerate !== want.degenerate)
                report("degenerate", got.degenerate, want.degenerate);
            n_checked++;
        endtask
    endclass

    logic      clk;
    logic      rst_n;
    logic      in_valid;
    logic      in_ready;
    tfn_pkg::t_in_item  in_item;
    logic      out_valid;
    logic      out_ready;
    tfn_pkg::t_out_item out_item;

    normal_scoreboard sb;
    tfn_pkg::t_in_item  triangles[$];
    logic      calm;
    int        n_sent;
    int        idle_cycles;

    triangle_face_normal_top dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_ready (in_ready),
        .i_item  (in_item),
        .o_valid (out_valid),
        .i_ready (out_ready),
        .o_item  (out_item)
    );

    always begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    function automatic logic signed [15:0] pick_coord();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2: return 16'sh0000;
            3, 4: return $signed(16'($urandom_range(0, 15) - 8));
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic tfn_pkg::t_in_item random_triangle();
        tfn_pkg::t_in_item t;
        logic [159:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom, $urandom};
        t = raw[$bits(tfn_pkg::t_in_item)-1:0];
        if ($urandom_range(0, 2) != 0) begin
            t.ax = pick_coord(); t.ay = pick_coord(); t.az = pick_coord();
            t.bx = pick_coord(); t.by_coord = pick_coord(); t.bz = pick_coord();
            t.cx = pick_coord(); t.cy = pick_coord(); t.cz = pick_coord();
        end
        // make some collinear or coincident
        if ($urandom_range(0, 15) == 0) begin
            t.bx = t.ax; t.by_coord = t.ay; t.bz = t.az;
        end
        return t;
    endfunction

    task automatic add_triangle(int a0, int a1, int a2, int b0, int b1, int b2,
                                int c0, int c1, int c2);
        tfn_pkg::t_in_item t;
        t.ax = tfn_pkg::COORD_WIDTH'(a0);
        t.ay = tfn_pkg::COORD_WIDTH'(a1);
        t.az = tfn_pkg::COORD_WIDTH'(a2);
        t.bx = tfn_pkg::COORD_WIDTH'(b0);
        t.by_coord = tfn_pkg::COORD_WIDTH'(b1);
        t.bz = tfn_pkg::COORD_WIDTH'(b2);
        t.cx = tfn_pkg::COORD_WIDTH'(c0);
        t.cy = tfn_pkg::COORD_WIDTH'(c1);
        t.cz = tfn_pkg::COORD_WIDTH'(c2);
        triangles = {triangles, t};
    endtask

    // Sender: hold valid and payload until taken
    task automatic send_triangles();
        tfn_pkg::t_in_item t;
        while (triangles.size() > 0) begin
            @(posedge clk);
            if (!in_valid || in_ready) begin
                if (in_valid && in_ready) sb.note_triangle(in_item);
                if (!calm && $urandom_range(0, 99) < 28) begin
                    in_valid <= 1'b0;
                end else begin
                    t = triangles.pop_front();
                    in_valid <= 1'b1;
                    in_item  <= t;
                    n_sent++;
                end
            end
        end
        do begin
            @(posedge clk);
        end while (!(in_valid && in_ready));
        sb.note_triangle(in_item);
        in_valid <= 1'b0;
    endtask

    // Result side: check on accept, stall at random
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready) sb.check_normal(out_item);
            out_ready <= calm || ($urandom_range(0, 99) >= 28);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("triangle_face_normal_top verification failed");
            $finish;
        end
    end

    initial begin
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        out_ready = 1'b0;
        calm = 1'b0;
        n_sent = 0;
        idle_cycles = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners: unit axes, degenerate, extreme spans
        add_triangle(0, 0, 0, 256, 0, 0, 0, 256, 0);
        add_triangle(0, 0, 0, 0, 256, 0, 0, 0, 256);
        add_triangle(0, 0, 0, 0, 0, 256, 256, 0, 0);
        add_triangle(0, 0, 0, 0, 256, 0, 256, 0, 0);
        add_triangle(5, 5, 5, 5, 5, 5, 5, 5, 5);
        add_triangle(0, 0, 0, 1, 1, 1, 2, 2, 2);
        add_triangle(0, 0, 0, 0, 0, 0, 100, 7, -3);
        add_triangle(-32768, -32768, -32768, 32767, -32768, -32768,
                     -32768, 32767, -32768);
        add_triangle(32767, 32767, 32767, -32768, 32767, 32767,
                     32767, -32768, 32767);
        add_triangle(-32768, -32768, -32768, 32767, 32767, -32768,
                     -32768, 32767, 32767);
        add_triangle(0, 0, 0, 1, 0, 0, 0, 1, 0);
        add_triangle(0, 0, 0, 32767, 1, 0, 1, 32767, 0);
        add_triangle(-32768, 0, 32767, 32767, -32768, 0, 0, 32767, -32768);
        add_triangle(0, 0, 0, 3, 0, 0, 0, 0, 1);
        add_triangle(0, 0, 0, 1, 1, 0, 1, 0, 1);
        add_triangle(0, 0, 0, -1, -1, -1, 32767, -32768, 1);
        for (int i = 0; i < N_RANDOM; i++) triangles = {triangles, random_triangle()};

        fork
            send_triangles();
            begin
                // no idling during a stretch in the middle
                wait (n_sent > 150);
                calm = 1'b1;
                wait (n_sent > 250);
                calm = 1'b0;
            end
        join

        while (sb.pending_normals.size() != 0) @(posedge clk);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Checked %0d face normals from %0d triangles, corner cases included.",
                 sb.n_checked, n_sent);
        if (sb.n_errors == 0 && sb.pending_normals.size() == 0)
            $display("triangle_face_normal_top verification clean");
        else
            $display("triangle_face_normal_top verification failed");
        $finish;
    end
endmodule
